### rtl/periodic_request_scheduler_macros.svh
// Assertion macros used by the checker of the periodic request scheduler.
`ifndef PERIODIC_REQUEST_SCHEDULER_MACROS_SVH
`define PERIODIC_REQUEST_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define PRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed (next cycle)");

`endif

### rtl/prs_pkg.sv
// Types and constants shared by the periodic request scheduler modules.
package prs_pkg;

    localparam logic [2:0] OP_CLEAR      = 3'd0;
    localparam logic [2:0] OP_ADD        = 3'd1;
    localparam logic [2:0] OP_SET_ENABLE = 3'd2;
    localparam logic [2:0] OP_PAUSE      = 3'd3;
    localparam logic [2:0] OP_RESUME     = 3'd4;
    localparam logic [2:0] OP_NEXT       = 3'd5;
    localparam logic [2:0] OP_DISPATCHED = 3'd6;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_INVALID   = 4'd1;
    localparam logic [3:0] ST_FULL      = 4'd2;
    localparam logic [3:0] ST_DUPLICATE = 4'd3;
    localparam logic [3:0] ST_NOT_FOUND = 4'd4;
    localparam logic [3:0] ST_READY     = 4'd5;
    localparam logic [3:0] ST_WAITING   = 4'd6;
    localparam logic [3:0] ST_PAUSED    = 4'd7;
    localparam logic [3:0] ST_EMPTY     = 4'd8;

    localparam logic CFG_OBD_PROTOCOL = 1'b0;
    localparam logic CFG_OBD_MODULE   = 1'b1;

    localparam logic [2:0] MAX_PRIORITY = 3'd3;
    localparam int         DIV_STEPS    = 64;

    typedef enum logic [1:0] {
        MODE_DONE,
        MODE_SCAN,
        MODE_DISP
    } mode_t;

    typedef struct packed {
        logic [3:0]  protocol;
        logic [7:0]  module_code;
        logic [31:0] identifier;
        logic [7:0]  pid;
        logic        pid_flag;
        logic [31:0] interval;
        logic [63:0] next_due;
        logic [1:0]  priority_lvl;
        logic        enabled;
    } entry_t;

    typedef struct packed {
        logic start;
        logic rd;
        logic eval;
        logic div_step;
        logic dwrite;
        logic finish;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  scan_more;
        logic  need_div;
        logic  div_done;
        logic  out_free;
    } sts_t;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

### rtl/prs_ctrl.sv
// Sequencer of the periodic request scheduler: decodes, scans, divides and retires.
module prs_ctrl import prs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t st,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_EVAL,
        S_DIV,
        S_DWRITE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (st.mode)
                    MODE_SCAN: state_next = st.scan_more ? S_READ : S_FINISH;
                    MODE_DISP: state_next = S_READ;
                    default:   state_next = S_FINISH;
                endcase
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (st.mode == MODE_DISP)
                begin
                    state_next = st.need_div ? S_DIV : S_FINISH;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_DWRITE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DWRITE:
            begin
                cmd.dwrite = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/prs_datapath.sv
// Datapath of the periodic request scheduler: entry table, scan accumulators, divider, result.
module prs_datapath import prs_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic [2:0]  operation,
    input  logic [3:0]  key_protocol,
    input  logic [7:0]  key_module,
    input  logic [31:0] key_identifier,
    input  logic [31:0] interval,
    input  logic [2:0]  priority_req,
    input  logic [63:0] first_due,
    input  logic        enable_flag,
    input  logic [4:0]  entry_index,
    input  logic [63:0] now,
    input  logic        rsp_ready,
    output logic        rsp_valid,
    output logic [3:0]  status,
    output logic [3:0]  out_index,
    output logic [3:0]  out_protocol,
    output logic [7:0]  out_module,
    output logic [31:0] out_identifier,
    output logic [7:0]  out_pid,
    output logic        out_pid_valid,
    output logic [63:0] due_time,
    output logic [63:0] wait_time,
    input  cmd_t        cmd,
    output sts_t        st
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    entry_t mem [MAX_ENTRIES];
    entry_t rdata_reg;
    logic [IW-1:0] cur_addr_reg;

    logic [3:0]  obd_proto_reg;
    logic [7:0]  obd_module_reg;

    logic [2:0]  op_reg;
    logic [3:0]  kp_reg;
    logic [7:0]  km_reg;
    logic [31:0] kid_reg;
    logic [31:0] ival_reg;
    logic [2:0]  prio_reg;
    logic [63:0] first_reg;
    logic        en_reg;
    logic [4:0]  idx_reg;
    logic [63:0] now_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg;
    logic          paused_reg, paused_next;
    logic [63:0]   pstart_reg, pstart_next;

    logic          found_reg;
    logic [IW-1:0] found_idx_reg;
    entry_t        found_entry_reg;
    logic          have_en_reg, due_found_reg;
    logic [63:0]   earliest_reg;
    logic [IW-1:0] sel_idx_reg;
    entry_t        sel_entry_reg;

    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [6:0]  div_cnt_reg;
    logic [32:0] rem_shift;

    logic          rsp_valid_reg;
    logic [3:0]    status_reg;
    logic [3:0]    out_index_reg;
    logic [3:0]    out_protocol_reg;
    logic [7:0]    out_module_reg;
    logic [31:0]   out_identifier_reg;
    logic [7:0]    out_pid_reg;
    logic          out_pid_valid_reg;
    logic [63:0]   due_time_reg;
    logic [63:0]   wait_time_reg;

    logic          we;
    logic [IW-1:0] waddr;
    entry_t        wdata;
    logic [IW-1:0] raddr;
    logic [63:0]   pause_len;
    logic          add_ok;
    logic          key_match;
    logic          pid_ok;
    logic          disp_in_range;
    logic [3:0]    fin_status;
    logic [3:0]    fin_index;
    entry_t        fin_entry;
    logic [63:0]   fin_due;
    logic [63:0]   fin_wait;
    logic          fin_ready;

    assign add_ok = (kp_reg != 4'd0) && (ival_reg != 32'd0) && (prio_reg <= MAX_PRIORITY);
    assign disp_in_range = (32'(idx_reg) < 32'(count_reg));
    assign pause_len = (now_reg >= pstart_reg) ? (now_reg - pstart_reg) : 64'd0;
    assign key_match = (rdata_reg.protocol == kp_reg) && (rdata_reg.module_code == km_reg)
                       && (rdata_reg.identifier == kid_reg);
    assign pid_ok = (kp_reg == obd_proto_reg) && (km_reg == obd_module_reg)
                    && (kid_reg <= 32'd255);
    assign raddr = (op_reg == OP_DISPATCHED) ? IW'(idx_reg) : ptr_reg[IW-1:0];
    assign rem_shift = {rem_reg, dvd_reg[63]};

    always_comb
    begin
        st.mode = MODE_DONE;
        case (op_reg)
            OP_ADD:        st.mode = add_ok ? MODE_SCAN : MODE_DONE;
            OP_SET_ENABLE: st.mode = (kp_reg != 4'd0) ? MODE_SCAN : MODE_DONE;
            OP_RESUME:     st.mode = paused_reg ? MODE_SCAN : MODE_DONE;
            OP_NEXT:       st.mode = paused_reg ? MODE_DONE : MODE_SCAN;
            OP_DISPATCHED: st.mode = disp_in_range ? MODE_DISP : MODE_DONE;
            default:       st.mode = MODE_DONE;
        endcase
        st.scan_more = (ptr_reg < count_reg);
        st.need_div  = !(rdata_reg.next_due > now_reg);
        st.div_done  = (div_cnt_reg == 7'(DIV_STEPS));
        st.out_free  = !rsp_valid_reg || rsp_ready;
    end

    // Table write port: one entry per cycle at most.
    always_comb
    begin
        we    = 1'b0;
        waddr = cur_addr_reg;
        wdata = rdata_reg;
        if (cmd.eval && op_reg == OP_RESUME)
        begin
            we             = 1'b1;
            wdata.next_due = sat_add64(rdata_reg.next_due, pause_len);
        end
        else if (cmd.eval && op_reg == OP_DISPATCHED && !st.need_div)
        begin
            we             = 1'b1;
            wdata.next_due = sat_add64(rdata_reg.next_due, 64'(rdata_reg.interval));
        end
        else if (cmd.dwrite)
        begin
            // The new deadline is now minus the remainder plus one interval.
            we             = 1'b1;
            wdata.next_due = sat_add64(now_reg - 64'(rem_reg), 64'(rdata_reg.interval));
        end
        else if (cmd.finish && op_reg == OP_ADD && add_ok && !found_reg
                 && (32'(count_reg) < MAX_ENTRIES))
        begin
            we                 = 1'b1;
            waddr              = count_reg[IW-1:0];
            wdata.protocol     = kp_reg;
            wdata.module_code  = km_reg;
            wdata.identifier   = kid_reg;
            wdata.pid_flag     = pid_ok;
            wdata.pid          = pid_ok ? kid_reg[7:0] : 8'd0;
            wdata.interval     = ival_reg;
            wdata.next_due     = first_reg;
            wdata.priority_lvl = prio_reg[1:0];
            wdata.enabled      = 1'b1;
        end
        else if (cmd.finish && op_reg == OP_SET_ENABLE && kp_reg != 4'd0 && found_reg)
        begin
            we            = 1'b1;
            waddr         = found_idx_reg;
            wdata         = found_entry_reg;
            wdata.enabled = en_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg    <= mem[raddr];
            cur_addr_reg <= raddr;
        end
    end

    // Result and control state changes at retirement.
    always_comb
    begin
        fin_status  = ST_OK;
        fin_index   = 4'd0;
        fin_entry   = '0;
        fin_due     = 64'd0;
        fin_wait    = 64'd0;
        fin_ready   = 1'b0;
        count_next  = count_reg;
        paused_next = paused_reg;
        pstart_next = pstart_reg;
        case (op_reg)
            OP_CLEAR:
            begin
                count_next  = '0;
                paused_next = 1'b0;
                pstart_next = 64'd0;
            end
            OP_ADD:
            begin
                if (!add_ok)
                begin
                    fin_status = ST_INVALID;
                end
                else if (found_reg)
                begin
                    fin_status = ST_DUPLICATE;
                end
                else if (32'(count_reg) >= MAX_ENTRIES)
                begin
                    fin_status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            OP_SET_ENABLE:
            begin
                if (kp_reg == 4'd0)
                begin
                    fin_status = ST_INVALID;
                end
                else if (!found_reg)
                begin
                    fin_status = ST_NOT_FOUND;
                end
            end
            OP_PAUSE:
            begin
                if (!paused_reg)
                begin
                    paused_next = 1'b1;
                    pstart_next = now_reg;
                end
            end
            OP_RESUME:
            begin
                paused_next = 1'b0;
                pstart_next = 64'd0;
            end
            OP_NEXT:
            begin
                if (paused_reg)
                begin
                    fin_status = ST_PAUSED;
                end
                else if (!have_en_reg)
                begin
                    fin_status = ST_EMPTY;
                end
                else if (!due_found_reg)
                begin
                    fin_status = ST_WAITING;
                    fin_due    = earliest_reg;
                    fin_wait   = (earliest_reg > now_reg) ? (earliest_reg - now_reg) : 64'd0;
                end
                else
                begin
                    fin_status = ST_READY;
                    fin_ready  = 1'b1;
                    fin_index  = 4'(sel_idx_reg);
                    fin_entry  = sel_entry_reg;
                    fin_due    = sel_entry_reg.next_due;
                end
            end
            OP_DISPATCHED:
            begin
                if (!disp_in_range)
                begin
                    fin_status = ST_INVALID;
                end
            end
            default: fin_status = ST_INVALID;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obd_proto_reg  <= 4'd1;
            obd_module_reg <= 8'd1;
            count_reg      <= '0;
            paused_reg     <= 1'b0;
            pstart_reg     <= 64'd0;
            rsp_valid_reg  <= 1'b0;
            ptr_reg        <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_OBD_PROTOCOL)
                begin
                    obd_proto_reg <= cfg_data[3:0];
                end
                else
                begin
                    obd_module_reg <= cfg_data;
                end
            end
            if (cmd.start)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.eval)
            begin
                ptr_reg <= ptr_reg + CW'(1);
            end
            if (cmd.eval)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 7'd1;
            end
            if (cmd.finish)
            begin
                count_reg     <= count_next;
                paused_reg    <= paused_next;
                pstart_reg    <= pstart_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg        <= operation;
            kp_reg        <= key_protocol;
            km_reg        <= key_module;
            kid_reg       <= key_identifier;
            ival_reg      <= interval;
            prio_reg      <= priority_req;
            first_reg     <= first_due;
            en_reg        <= enable_flag;
            idx_reg       <= entry_index;
            now_reg       <= now;
            found_reg     <= 1'b0;
            have_en_reg   <= 1'b0;
            due_found_reg <= 1'b0;
            earliest_reg  <= {64{1'b1}};
        end
        if (cmd.eval)
        begin
            if ((op_reg == OP_ADD || op_reg == OP_SET_ENABLE) && key_match && !found_reg)
            begin
                found_reg       <= 1'b1;
                found_idx_reg   <= cur_addr_reg;
                found_entry_reg <= rdata_reg;
            end
            if (op_reg == OP_NEXT && rdata_reg.enabled)
            begin
                if (!have_en_reg || rdata_reg.next_due < earliest_reg)
                begin
                    earliest_reg <= rdata_reg.next_due;
                end
                have_en_reg <= 1'b1;
                // Earlier deadline wins, then higher priority; a later index never wins a tie.
                if (rdata_reg.next_due <= now_reg
                    && (!due_found_reg || rdata_reg.next_due < sel_entry_reg.next_due
                        || (rdata_reg.next_due == sel_entry_reg.next_due
                            && rdata_reg.priority_lvl > sel_entry_reg.priority_lvl)))
                begin
                    due_found_reg <= 1'b1;
                    sel_idx_reg   <= cur_addr_reg;
                    sel_entry_reg <= rdata_reg;
                end
            end
            dvd_reg <= now_reg - rdata_reg.next_due;
            rem_reg <= 32'd0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            if (rem_shift >= {1'b0, rdata_reg.interval})
            begin
                rem_reg <= 32'(rem_shift - {1'b0, rdata_reg.interval});
            end
            else
            begin
                rem_reg <= rem_shift[31:0];
            end
        end
        if (cmd.finish)
        begin
            status_reg         <= fin_status;
            out_index_reg      <= fin_index;
            out_protocol_reg   <= fin_ready ? fin_entry.protocol : 4'd0;
            out_module_reg     <= fin_ready ? fin_entry.module_code : 8'd0;
            out_identifier_reg <= fin_ready ? fin_entry.identifier : 32'd0;
            out_pid_reg        <= fin_ready ? fin_entry.pid : 8'd0;
            out_pid_valid_reg  <= fin_ready && fin_entry.pid_flag;
            due_time_reg       <= fin_due;
            wait_time_reg      <= fin_wait;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign out_index      = out_index_reg;
    assign out_protocol   = out_protocol_reg;
    assign out_module     = out_module_reg;
    assign out_identifier = out_identifier_reg;
    assign out_pid        = out_pid_reg;
    assign out_pid_valid  = out_pid_valid_reg;
    assign due_time       = due_time_reg;
    assign wait_time      = wait_time_reg;

endmodule

### rtl/periodic_request_scheduler.sv
// Periodic request scheduler: one transaction in, one result transaction out. Items are taken
// one at a time. Clear, pause and rejected operations go straight from decode to retirement;
// add, set enable, resume and next scan the table through its single read port, reading and
// then evaluating each stored entry in turn; dispatched reads and evaluates one entry and,
// if its deadline has passed, runs the 64-step serial remainder unit and writes the deadline.
// A finished result waits in the output register until taken; the next transaction is accepted
// once the sequencer is idle again. The entry table needs no clearing after reset.
module periodic_request_scheduler import prs_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  operation,
    input  logic [3:0]  key_protocol,
    input  logic [7:0]  key_module,
    input  logic [31:0] key_identifier,
    input  logic [31:0] interval,
    input  logic [2:0]  priority_req,
    input  logic [63:0] first_due,
    input  logic        enable_flag,
    input  logic [4:0]  entry_index,
    input  logic [63:0] now,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [3:0]  status,
    output logic [3:0]  out_index,
    output logic [3:0]  out_protocol,
    output logic [7:0]  out_module,
    output logic [31:0] out_identifier,
    output logic [7:0]  out_pid,
    output logic        out_pid_valid,
    output logic [63:0] due_time,
    output logic [63:0] wait_time
);

    cmd_t cmd;
    sts_t st;

    prs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    prs_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .key_protocol   (key_protocol),
        .key_module     (key_module),
        .key_identifier (key_identifier),
        .interval       (interval),
        .priority_req   (priority_req),
        .first_due      (first_due),
        .enable_flag    (enable_flag),
        .entry_index    (entry_index),
        .now            (now),
        .rsp_ready      (rsp_ready),
        .rsp_valid      (rsp_valid),
        .status         (status),
        .out_index      (out_index),
        .out_protocol   (out_protocol),
        .out_module     (out_module),
        .out_identifier (out_identifier),
        .out_pid        (out_pid),
        .out_pid_valid  (out_pid_valid),
        .due_time       (due_time),
        .wait_time      (wait_time),
        .cmd            (cmd),
        .st             (st)
    );

endmodule

### rtl/prs_checker.sv
// Port-level checks of the periodic request scheduler and their binding.
`include "periodic_request_scheduler_macros.svh"

module prs_checker import prs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [3:0]  status,
    input logic [3:0]  out_index,
    input logic        out_pid_valid,
    input logic [63:0] wait_time
);

    `PRS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status))
    `PRS_ASSERT_IMPLIES(a_sel_only_ready, clk, rst_n, rsp_valid && status != ST_READY, !out_pid_valid && out_index == 4'd0)
    `PRS_ASSERT_IMPLIES(a_wait_only_waiting, clk, rst_n, rsp_valid && status != ST_WAITING, wait_time == 64'd0)
    `PRS_ASSERT_IMPLIES(a_waiting_nonzero, clk, rst_n, rsp_valid && status == ST_WAITING, wait_time != 64'd0)

endmodule

bind periodic_request_scheduler prs_checker u_prs_checker (.*);

### test/tb_periodic_request_scheduler.sv
// Self-checking testbench for the periodic request scheduler, with its own table predictor.
`timescale 1ns / 1ps

module tb_periodic_request_scheduler;
    import prs_pkg::*;

    localparam int  TABLE_DEPTH = 16;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  SETTLE      = 80;
    localparam logic [63:0] T_MAX = {64{1'b1}};
    localparam logic [2:0]  OP_RESERVED = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [3:0]  proto;
        logic [7:0]  modc;
        logic [31:0] ident;
        logic [31:0] ival;
        logic [2:0]  prio;
        logic [63:0] first;
        logic        en;
        logic [4:0]  idx;
        logic [63:0] tnow;
    } request_t;

    typedef struct {
        logic [3:0]  status;
        logic [3:0]  idx;
        logic [3:0]  proto;
        logic [7:0]  modc;
        logic [31:0] ident;
        logic [7:0]  pid;
        logic        pid_ok;
        logic [63:0] due;
        logic [63:0] waitt;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        req_valid;
    logic        req_ready;
    logic [2:0]  operation;
    logic [3:0]  key_protocol;
    logic [7:0]  key_module;
    logic [31:0] key_identifier;
    logic [31:0] interval;
    logic [2:0]  priority_req;
    logic [63:0] first_due;
    logic        enable_flag;
    logic [4:0]  entry_index;
    logic [63:0] now;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [3:0]  status;
    logic [3:0]  out_index;
    logic [3:0]  out_protocol;
    logic [7:0]  out_module;
    logic [31:0] out_identifier;
    logic [7:0]  out_pid;
    logic        out_pid_valid;
    logic [63:0] due_time;
    logic [63:0] wait_time;

    periodic_request_scheduler u_dut (.*);

    // Predicted scheduler state.
    logic [3:0]  pid_proto_code;
    logic [7:0]  pid_module_code;
    int          stored;
    logic        halted;
    logic [63:0] halt_start;
    logic [3:0]  tab_proto [TABLE_DEPTH];
    logic [7:0]  tab_mod   [TABLE_DEPTH];
    logic [31:0] tab_ident [TABLE_DEPTH];
    logic [7:0]  tab_pid   [TABLE_DEPTH];
    logic        tab_pidok [TABLE_DEPTH];
    logic [31:0] tab_ival  [TABLE_DEPTH];
    logic [63:0] tab_due   [TABLE_DEPTH];
    logic [1:0]  tab_prio  [TABLE_DEPTH];
    logic        tab_en    [TABLE_DEPTH];

    answer_t     pending_answers[$];
    int          errors;
    int          cycles;
    bit          calm;
    int          rsp_hold;
    logic [63:0] clock_ms;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? T_MAX : s[63:0];
    endfunction

    function automatic int find_entry(logic [3:0] p, logic [7:0] m, logic [31:0] id);
        for (int i = 0; i < stored; i++)
            if (tab_proto[i] == p && tab_mod[i] == m && tab_ident[i] == id)
                return i;
        return stored;
    endfunction

    function automatic answer_t schedule_answer(request_t r);
        answer_t     a;
        int          k;
        int          sel;
        bit          have_en;
        bit          due_hit;
        logic [63:0] earliest;
        logic [63:0] d;
        logic [63:0] steps;
        logic [127:0] prod;
        bit          pv;
        a = '{default: '0};
        a.status = ST_OK;
        case (r.op)
            OP_CLEAR: begin
                stored = 0;
                halted = 1'b0;
                halt_start = '0;
            end
            OP_ADD: begin
                if (r.proto == 0 || r.ival == 0 || r.prio > MAX_PRIORITY)
                    a.status = ST_INVALID;
                else if (find_entry(r.proto, r.modc, r.ident) < stored)
                    a.status = ST_DUPLICATE;
                else if (stored >= TABLE_DEPTH)
                    a.status = ST_FULL;
                else begin
                    pv = (r.proto == pid_proto_code) && (r.modc == pid_module_code)
                         && (r.ident <= 255);
                    tab_proto[stored] = r.proto;
                    tab_mod[stored]   = r.modc;
                    tab_ident[stored] = r.ident;
                    tab_pidok[stored] = pv;
                    tab_pid[stored]   = pv ? r.ident[7:0] : 8'd0;
                    tab_ival[stored]  = r.ival;
                    tab_due[stored]   = r.first;
                    tab_prio[stored]  = r.prio[1:0];
                    tab_en[stored]    = 1'b1;
                    stored++;
                end
            end
            OP_SET_ENABLE: begin
                if (r.proto == 0)
                    a.status = ST_INVALID;
                else begin
                    k = find_entry(r.proto, r.modc, r.ident);
                    if (k < stored) tab_en[k] = r.en;
                    else a.status = ST_NOT_FOUND;
                end
            end
            OP_PAUSE: begin
                if (!halted) begin
                    halted = 1'b1;
                    halt_start = r.tnow;
                end
            end
            OP_RESUME: begin
                if (halted) begin
                    d = (r.tnow >= halt_start) ? r.tnow - halt_start : 64'd0;
                    for (int i = 0; i < stored; i++) tab_due[i] = add_clamped(tab_due[i], d);
                    halted = 1'b0;
                    halt_start = '0;
                end
            end
            OP_NEXT: begin
                if (halted)
                    a.status = ST_PAUSED;
                else begin
                    have_en = 0;
                    due_hit = 0;
                    sel = 0;
                    earliest = T_MAX;
                    for (int i = 0; i < stored; i++) begin
                        if (tab_en[i]) begin
                            d = tab_due[i];
                            if (!have_en || d < earliest) earliest = d;
                            have_en = 1;
                            if (d <= r.tnow && (!due_hit || d < tab_due[sel] ||
                                (d == tab_due[sel] && tab_prio[i] > tab_prio[sel]))) begin
                                sel = i;
                                due_hit = 1;
                            end
                        end
                    end
                    if (!have_en)
                        a.status = ST_EMPTY;
                    else if (!due_hit) begin
                        a.status = ST_WAITING;
                        a.due = earliest;
                        a.waitt = (earliest > r.tnow) ? earliest - r.tnow : 64'd0;
                    end else begin
                        a.status = ST_READY;
                        a.idx    = sel[3:0];
                        a.proto  = tab_proto[sel];
                        a.modc   = tab_mod[sel];
                        a.ident  = tab_ident[sel];
                        a.pid    = tab_pid[sel];
                        a.pid_ok = tab_pidok[sel];
                        a.due    = tab_due[sel];
                    end
                end
            end
            OP_DISPATCHED: begin
                k = r.idx;
                if (k >= stored || tab_ival[k] == 0)
                    a.status = ST_INVALID;
                else begin
                    d = tab_due[k];
                    if (d > r.tnow)
                        tab_due[k] = add_clamped(d, {32'd0, tab_ival[k]});
                    else begin
                        steps = add_clamped((r.tnow - d) / {32'd0, tab_ival[k]}, 64'd1);
                        prod = {96'd0, tab_ival[k]} * {64'd0, steps};
                        tab_due[k] = add_clamped(d, (prod[127:64] != 0) ? T_MAX : prod[63:0]);
                    end
                end
            end
            default: a.status = ST_INVALID;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
        if (got !== want) report_mismatch(field, got, want);
    endtask

    // Result side: random back-pressure and comparison with the oldest prediction.
    always @(posedge clk) begin
        answer_t w;
        if (!rst_n) begin
            rsp_hold <= 0;
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("unexpected result transaction", 64'd1, 64'd0);
                end else begin
                    w = pending_answers.pop_front();
                    check_field("status", status, w.status);
                    check_field("out_index", out_index, w.idx);
                    check_field("out_protocol", out_protocol, w.proto);
                    check_field("out_module", out_module, w.modc);
                    check_field("out_identifier", out_identifier, w.ident);
                    check_field("out_pid", out_pid, w.pid);
                    check_field("out_pid_valid", out_pid_valid, w.pid_ok);
                    check_field("due_time", due_time, w.due);
                    check_field("wait_time", wait_time, w.waitt);
                end
            end
            if (rsp_hold > 0) begin
                rsp_hold <= rsp_hold - 1;
                rsp_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                rsp_hold <= $urandom_range(0, 2);
                rsp_ready <= 1'b0;
            end else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(request_t r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        operation      <= r.op;
        key_protocol   <= r.proto;
        key_module     <= r.modc;
        key_identifier <= r.ident;
        interval       <= r.ival;
        priority_req   <= r.prio;
        first_due      <= r.first;
        enable_flag    <= r.en;
        entry_index    <= r.idx;
        now            <= r.tnow;
        req_valid      <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        pending_answers.push_back(schedule_answer(r));
    endtask

    task automatic drain;
        req_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [7:0] value);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_OBD_PROTOCOL) pid_proto_code = value[3:0];
        else pid_module_code = value;
    endtask

    function automatic request_t make_request(logic [2:0] op, logic [3:0] p, logic [7:0] m,
                                              logic [31:0] id, logic [31:0] iv, logic [2:0] pr,
                                              logic [63:0] fd, logic en, logic [4:0] ix,
                                              logic [63:0] t);
        request_t r;
        r = '{op, p, m, id, iv, pr, fd, en, ix, t};
        return r;
    endfunction

    function automatic logic [63:0] random_time(logic [63:0] base);
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return T_MAX - $urandom_range(0, 100);
            default: return base + $urandom_range(0, 200) - 40;
        endcase
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        r.proto = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        r.modc  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
        r.ident = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(250, 262);
        case ($urandom_range(0, 9))
            0: r.ival = 0;
            1: r.ival = $urandom;
            2: r.ival = 32'hFFFF_FFFF;
            default: r.ival = $urandom_range(1, 100);
        endcase
        r.prio  = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3));
        r.first = random_time(clock_ms);
        r.en    = 1'($urandom);
        r.idx   = ($urandom_range(0, 4) == 0 || stored == 0) ? 5'($urandom)
                                                            : 5'($urandom_range(0, stored - 1));
        r.tnow  = random_time(clock_ms);
        pick = $urandom_range(0, 99);
        if (pick < 2)       r.op = OP_CLEAR;
        else if (pick < 30) r.op = OP_ADD;
        else if (pick < 40) r.op = OP_SET_ENABLE;
        else if (pick < 45) r.op = OP_PAUSE;
        else if (pick < 50) r.op = OP_RESUME;
        else if (pick < 75) r.op = OP_NEXT;
        else if (pick < 98) r.op = OP_DISPATCHED;
        else                r.op = OP_RESERVED;
        return r;
    endfunction

    task automatic test_add_rules;
        send_request(make_request(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_ADD, 1, 1, 5, 10, 1, 100, 0, 0, 0));
        send_request(make_request(OP_ADD, 1, 1, 300, 20, 3, 100, 0, 0, 0));
        send_request(make_request(OP_ADD, 1, 1, 5, 10, 1, 100, 0, 0, 0));
        send_request(make_request(OP_ADD, 0, 1, 6, 10, 1, 100, 0, 0, 0));
        send_request(make_request(OP_ADD, 1, 1, 7, 0, 1, 100, 0, 0, 0));
        send_request(make_request(OP_ADD, 1, 1, 8, 10, 4, 100, 0, 0, 0));
        send_request(make_request(OP_ADD, 15, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7, T_MAX, 1,
                                  31, T_MAX));
        send_request(make_request(OP_SET_ENABLE, 0, 1, 5, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_SET_ENABLE, 2, 9, 5, 0, 0, 0, 1, 0, 0));
        send_request(make_request(OP_RESERVED, 15, 255, 32'hFFFF_FFFF, 1, 7, T_MAX, 1, 31,
                                  T_MAX));
    endtask

    task automatic test_selection_and_dispatch;
        send_request(make_request(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 50));
        send_request(make_request(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 100));
        send_request(make_request(OP_SET_ENABLE, 1, 1, 300, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 100));
        send_request(make_request(OP_DISPATCHED, 0, 0, 0, 0, 0, 0, 0, 0, 255));
        send_request(make_request(OP_DISPATCHED, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_DISPATCHED, 0, 0, 0, 0, 0, 0, 0, 20, 0));
        send_request(make_request(OP_DISPATCHED, 0, 0, 0, 0, 0, 0, 0, 1, T_MAX));
        send_request(make_request(OP_SET_ENABLE, 1, 1, 300, 0, 0, 0, 1, 0, 0));
        send_request(make_request(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, T_MAX));
    endtask

    task automatic test_pause_resume;
        send_request(make_request(OP_PAUSE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_PAUSE, 0, 0, 0, 0, 0, 0, 0, 0, 500));
        send_request(make_request(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 500));
        send_request(make_request(OP_DISPATCHED, 0, 0, 0, 0, 0, 0, 0, 0, 600));
        send_request(make_request(OP_RESUME, 0, 0, 0, 0, 0, 0, 0, 0, T_MAX));
        send_request(make_request(OP_RESUME, 0, 0, 0, 0, 0, 0, 0, 0, 10));
        // A resume earlier than the pause start must not move any deadline.
        send_request(make_request(OP_PAUSE, 0, 0, 0, 0, 0, 0, 0, 0, 1000));
        send_request(make_request(OP_RESUME, 0, 0, 0, 0, 0, 0, 0, 0, 10));
        send_request(make_request(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_table_full;
        send_request(make_request(OP_PAUSE, 0, 0, 0, 0, 0, 0, 0, 0, 7));
        send_request(make_request(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i <= TABLE_DEPTH; i++)
            send_request(make_request(OP_ADD, 1, 1, i, 5, 2, 3, 0, 0, 0));
        send_request(make_request(OP_ADD, 1, 1, 0, 5, 2, 3, 0, 0, 0));
        send_request(make_request(OP_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 3));
        send_request(make_request(OP_DISPATCHED, 0, 0, 0, 0, 0, 0, 0, 15, 3));
    endtask

    task automatic test_random_traffic(int count);
        request_t r;
        for (int n = 0; n < count; n++) begin
            clock_ms = clock_ms + $urandom_range(0, 30);
            r = random_request();
            send_request(r);
            // Let all outstanding results drain once, halfway through, before continuing.
            if (n == count / 2) drain();
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        req_valid = 1'b0;
        operation = '0;
        key_protocol = '0;
        key_module = '0;
        key_identifier = '0;
        interval = '0;
        priority_req = '0;
        first_due = '0;
        enable_flag = 1'b0;
        entry_index = '0;
        now = '0;
        calm = 0;
        clock_ms = 64'd1000;
        pid_proto_code = 4'd1;
        pid_module_code = 8'd1;
        stored = 0;
        halted = 1'b0;
        halt_start = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_add_rules();
        test_selection_and_dispatch();
        test_pause_resume();
        test_table_full();
        test_random_traffic(100);
        write_register(CFG_OBD_PROTOCOL, 8'd15);
        write_register(CFG_OBD_MODULE, 8'd255);
        test_add_rules();
        test_random_traffic(80);
        write_register(CFG_OBD_PROTOCOL, 8'd0);
        write_register(CFG_OBD_MODULE, 8'd0);
        test_random_traffic(60);
        write_register(CFG_OBD_PROTOCOL, 8'd2);
        write_register(CFG_OBD_MODULE, 8'd2);
        test_random_traffic(80);
        write_register(CFG_OBD_PROTOCOL, 8'd1);
        write_register(CFG_OBD_MODULE, 8'd1);
        calm = 1;
        test_random_traffic(80);

        drain();
        repeat (SETTLE) @(posedge clk);
        if (pending_answers.size() != 0)
            report_mismatch("results outstanding", 64'(pending_answers.size()), 64'd0);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/prs_pkg.sv
rtl/prs_ctrl.sv
rtl/prs_datapath.sv
rtl/periodic_request_scheduler.sv
rtl/prs_checker.sv
test/tb_periodic_request_scheduler.sv
